// ===== rtl/alle_pkg.sv =====
package alle_pkg;

  // Fixed widths of the beat fields.
  localparam int unsigned NodeW       = 10;
  localparam int unsigned LinkOutW    = 11;
  localparam int unsigned MaxNodesDef = 1024;

  typedef enum logic [1:0] {
    REQ_INS_LEFT  = 2'd0,
    REQ_INS_RIGHT = 2'd1,
    REQ_REMOVE    = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_IGNORED     = 2'd1,
    ST_FULL        = 2'd2,
    ST_NOT_CREATED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_WR2  = 2'd2
  } state_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [NodeW-1:0] node;
    logic             read_only;
  } in_beat_t;

  typedef struct packed {
    status_e             status;
    logic [NodeW-1:0]    new_node;
    logic [LinkOutW-1:0] left_link;
    logic [LinkOutW-1:0] right_link;
    logic [NodeW-1:0]    head_node;
    logic [NodeW-1:0]    tail_node;
  } out_beat_t;

  // Decisions of the execute step.
  typedef struct packed {
    logic upd;    // list changes, a second write cycle follows
    logic grow;   // a node id was handed out
    logic l_wr1;
    logic l_wr2;
    logic r_wr1;
    logic r_wr2;
  } exec_flags_t;

  // Sequencer strobes.
  typedef struct packed {
    logic accept;
    logic exec;
    logic wr2;
  } ctl_t;

endpackage

// ===== rtl/alle_ram.sv =====
module alle_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/alle_exec.sv =====
module alle_exec import alle_pkg::*; #(
  parameter int unsigned MaxNodes = MaxNodesDef
) (
  input  in_beat_t                            req_i,
  input  logic [$clog2(MaxNodes+1)-1:0]       left_i,
  input  logic [$clog2(MaxNodes+1)-1:0]       right_i,
  input  logic [$clog2(MaxNodes)-1:0]         head_i,
  input  logic [$clog2(MaxNodes)-1:0]         tail_i,
  input  logic [$clog2(MaxNodes+1)-1:0]       cnt_i,
  output logic [$clog2(MaxNodes)-1:0]         head_o,
  output logic [$clog2(MaxNodes)-1:0]         tail_o,
  output exec_flags_t                         flags_o,
  output logic [$clog2(MaxNodes)-1:0]         l_wr1_addr_o,
  output logic [$clog2(MaxNodes+1)-1:0]       l_wr1_data_o,
  output logic [$clog2(MaxNodes)-1:0]         l_wr2_addr_o,
  output logic [$clog2(MaxNodes+1)-1:0]       l_wr2_data_o,
  output logic [$clog2(MaxNodes)-1:0]         r_wr1_addr_o,
  output logic [$clog2(MaxNodes+1)-1:0]       r_wr1_data_o,
  output logic [$clog2(MaxNodes)-1:0]         r_wr2_addr_o,
  output logic [$clog2(MaxNodes+1)-1:0]       r_wr2_data_o,
  output out_beat_t                           res_o
);

  localparam int unsigned IdW   = $clog2(MaxNodes);
  localparam int unsigned LinkW = $clog2(MaxNodes + 1);
  localparam int unsigned CmpW  = (LinkW > NodeW) ? LinkW : NodeW;
  localparam logic [LinkW-1:0] NoneId = LinkW'(MaxNodes);

  logic [IdW-1:0]   a;
  logic [IdW-1:0]   n;
  logic             not_created;
  logic             full;
  logic             p_none;
  logic             q_none;
  logic             isolated;
  status_e          status;
  logic [IdW-1:0]   new_id;
  logic [LinkW-1:0] ll;
  logic [LinkW-1:0] rl;

  always_comb begin
    a           = IdW'(req_i.node);
    n           = IdW'(cnt_i);
    not_created = CmpW'(req_i.node) >= CmpW'(cnt_i);
    full        = (cnt_i == NoneId);
    p_none      = (left_i == NoneId);
    q_none      = (right_i == NoneId);
    isolated    = p_none && q_none && (head_i != a);

    status       = ST_DONE;
    new_id       = '0;
    ll           = left_i;
    rl           = right_i;
    head_o       = head_i;
    tail_o       = tail_i;
    flags_o      = '0;
    l_wr1_addr_o = '0;
    l_wr1_data_o = '0;
    l_wr2_addr_o = '0;
    l_wr2_data_o = '0;
    r_wr1_addr_o = '0;
    r_wr1_data_o = '0;
    r_wr2_addr_o = '0;
    r_wr2_data_o = '0;

    if (not_created) begin
      status = ST_NOT_CREATED;
      ll     = NoneId;
      rl     = NoneId;
    end else if (!req_i.read_only) begin
      case (req_i.req_type)
        REQ_INS_LEFT, REQ_INS_RIGHT: begin
          if (full) begin
            status = ST_FULL;
          end else if (isolated) begin
            status = ST_IGNORED;
          end else begin
            flags_o.upd  = 1'b1;
            flags_o.grow = 1'b1;
            new_id       = n;
            if (req_i.req_type == REQ_INS_LEFT) begin
              // New node goes between the left neighbor and the named node.
              if (p_none) begin
                head_o = n;
              end
              flags_o.l_wr1 = 1'b1;
              l_wr1_addr_o  = a;
              l_wr1_data_o  = LinkW'(n);
              flags_o.l_wr2 = 1'b1;
              l_wr2_addr_o  = n;
              l_wr2_data_o  = left_i;
              flags_o.r_wr1 = 1'b1;
              r_wr1_addr_o  = n;
              r_wr1_data_o  = LinkW'(a);
              flags_o.r_wr2 = !p_none;
              r_wr2_addr_o  = IdW'(left_i);
              r_wr2_data_o  = LinkW'(n);
              ll            = LinkW'(n);
            end else begin
              if (q_none) begin
                tail_o = n;
              end
              flags_o.r_wr1 = 1'b1;
              r_wr1_addr_o  = a;
              r_wr1_data_o  = LinkW'(n);
              flags_o.r_wr2 = 1'b1;
              r_wr2_addr_o  = n;
              r_wr2_data_o  = right_i;
              flags_o.l_wr1 = 1'b1;
              l_wr1_addr_o  = n;
              l_wr1_data_o  = LinkW'(a);
              flags_o.l_wr2 = !q_none;
              l_wr2_addr_o  = IdW'(right_i);
              l_wr2_data_o  = LinkW'(n);
              rl            = LinkW'(n);
            end
          end
        end
        REQ_REMOVE: begin
          if (p_none && q_none) begin
            status = ST_IGNORED;
          end else begin
            flags_o.upd = 1'b1;
            if (p_none) begin
              head_o = IdW'(right_i);
            end
            if (q_none) begin
              tail_o = IdW'(left_i);
            end
            // The neighbors close the gap; the named node loses both links.
            flags_o.l_wr1 = 1'b1;
            l_wr1_addr_o  = a;
            l_wr1_data_o  = NoneId;
            flags_o.l_wr2 = !q_none;
            l_wr2_addr_o  = IdW'(right_i);
            l_wr2_data_o  = left_i;
            flags_o.r_wr1 = 1'b1;
            r_wr1_addr_o  = a;
            r_wr1_data_o  = NoneId;
            flags_o.r_wr2 = !p_none;
            r_wr2_addr_o  = IdW'(left_i);
            r_wr2_data_o  = right_i;
            ll            = NoneId;
            rl            = NoneId;
          end
        end
        default: begin
          status = ST_IGNORED;
        end
      endcase
    end

    res_o.status     = status;
    res_o.new_node   = NodeW'(new_id);
    res_o.left_link  = LinkOutW'(ll);
    res_o.right_link = LinkOutW'(rl);
    res_o.head_node  = NodeW'(head_o);
    res_o.tail_node  = NodeW'(tail_o);
  end

endmodule

// ===== rtl/alle_ctrl.sv =====
module alle_ctrl import alle_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic res_free_i,
  input  logic upd_i,
  output logic in_stall_o,
  output ctl_t ctl_o
);

  state_e state_q;
  state_e state_d;
  logic   open_w;

  assign open_w = ((state_q == S_IDLE) || (state_q == S_WR2)) && res_free_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && open_w) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = upd_i ? S_WR2 : S_IDLE;
      end
      S_WR2: begin
        state_d = (in_valid_i && open_w) ? S_EXEC : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o   = !open_w;
    ctl_o.accept = in_valid_i && open_w;
    ctl_o.exec   = (state_q == S_EXEC);
    ctl_o.wr2    = (state_q == S_WR2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/array_linked_list_engine_core.sv =====
// Ordered list of node ids kept as a doubly linked list in two link tables.
// Input channel: in_valid_i / in_stall_o with one in_beat_t per beat (insert
// left of a node, insert right of a node, remove a node, or a read of a
// node's links). Output channel: out_valid_o / out_stall_i with one
// out_beat_t per input beat, in order; every result carries head and tail,
// so the list can be walked from the head with reads.
// Timing: a beat accepted at one edge is executed in the next cycle, where
// both link tables return the named node's links. A request that changes
// the list goes through the S_WR2 state for the second write to each table,
// since each table has one write port. The result is registered in the skid
// register at the end of the execute cycle and then moves to the output
// register. No beat is taken in the execute cycle; one can be in S_WR2.
// After reset the list holds node 0 alone; link entries are only trusted
// once written, and node 0's entries read as none until first written, so
// there is no clearing pass. A stalled output holds its beat, and one more
// finished result can wait in a skid register behind it before the input
// stalls.
module array_linked_list_engine_core import alle_pkg::*; #(
  parameter int unsigned MaxNodes = MaxNodesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  localparam int unsigned IdW   = $clog2(MaxNodes);
  localparam int unsigned LinkW = $clog2(MaxNodes + 1);
  localparam logic [LinkW-1:0] NoneId = LinkW'(MaxNodes);

  ctl_t        ctl;
  exec_flags_t fl;

  // Request held for the execute cycle.
  in_beat_t    req_q;

  // List registers.
  logic [IdW-1:0]   head_q;
  logic [IdW-1:0]   tail_q;
  logic [LinkW-1:0] cnt_q;
  logic [IdW-1:0]   head_d;
  logic [IdW-1:0]   tail_d;

  // Node 0 has never been written at reset; these mark its first write.
  logic l0_ok_q;
  logic r0_ok_q;
  logic l0_none_q;
  logic r0_none_q;

  // Forwarding of an S_WR2 write that lands on the address being read.
  logic             fwd_l_q;
  logic             fwd_r_q;
  logic [LinkW-1:0] fwd_l_data_q;
  logic [LinkW-1:0] fwd_r_data_q;

  // Writes held for the S_WR2 state.
  logic             l_wr2_en_q;
  logic [IdW-1:0]   l_wr2_addr_q;
  logic [LinkW-1:0] l_wr2_data_q;
  logic             r_wr2_en_q;
  logic [IdW-1:0]   r_wr2_addr_q;
  logic [LinkW-1:0] r_wr2_data_q;

  logic [IdW-1:0]   l_wr1_addr;
  logic [LinkW-1:0] l_wr1_data;
  logic [IdW-1:0]   l_wr2_addr;
  logic [LinkW-1:0] l_wr2_data;
  logic [IdW-1:0]   r_wr1_addr;
  logic [LinkW-1:0] r_wr1_data;
  logic [IdW-1:0]   r_wr2_addr;
  logic [LinkW-1:0] r_wr2_data;

  // Memory ports.
  logic             l_we;
  logic [IdW-1:0]   l_waddr;
  logic [LinkW-1:0] l_wdata;
  logic             r_we;
  logic [IdW-1:0]   r_waddr;
  logic [LinkW-1:0] r_wdata;
  logic [IdW-1:0]   rd_addr;
  logic [LinkW-1:0] l_rdata;
  logic [LinkW-1:0] r_rdata;
  logic [LinkW-1:0] left_eff;
  logic [LinkW-1:0] right_eff;

  // Result skid register and output register.
  out_beat_t res_beat;
  out_beat_t res_q;
  logic      res_valid_q;
  out_beat_t out_q;
  logic      out_valid_q;
  logic      res_move;

  assign rd_addr  = IdW'(in_data_i.node);
  assign res_move = res_valid_q && (!out_valid_q || !out_stall_i);

  alle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .res_free_i (!res_valid_q || res_move),
    .upd_i      (fl.upd),
    .in_stall_o (in_stall_o),
    .ctl_o      (ctl)
  );

  // The first write of a request goes out in the execute cycle, the second
  // one in the following cycle from the registered command.
  always_comb begin
    l_we    = (ctl.exec && fl.l_wr1) || (ctl.wr2 && l_wr2_en_q);
    l_waddr = ctl.exec ? l_wr1_addr : l_wr2_addr_q;
    l_wdata = ctl.exec ? l_wr1_data : l_wr2_data_q;
    r_we    = (ctl.exec && fl.r_wr1) || (ctl.wr2 && r_wr2_en_q);
    r_waddr = ctl.exec ? r_wr1_addr : r_wr2_addr_q;
    r_wdata = ctl.exec ? r_wr1_data : r_wr2_data_q;
  end

  alle_ram #(
    .Width (LinkW),
    .Depth (MaxNodes)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .re_i    (ctl.accept),
    .raddr_i (rd_addr),
    .rdata_o (l_rdata)
  );

  alle_ram #(
    .Width (LinkW),
    .Depth (MaxNodes)
  ) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .re_i    (ctl.accept),
    .raddr_i (rd_addr),
    .rdata_o (r_rdata)
  );

  // Forwarded data wins; an unwritten node 0 reads as no neighbor.
  always_comb begin
    if (fwd_l_q) begin
      left_eff = fwd_l_data_q;
    end else if (l0_none_q) begin
      left_eff = NoneId;
    end else begin
      left_eff = l_rdata;
    end
    if (fwd_r_q) begin
      right_eff = fwd_r_data_q;
    end else if (r0_none_q) begin
      right_eff = NoneId;
    end else begin
      right_eff = r_rdata;
    end
  end

  alle_exec #(
    .MaxNodes (MaxNodes)
  ) u_exec (
    .req_i        (req_q),
    .left_i       (left_eff),
    .right_i      (right_eff),
    .head_i       (head_q),
    .tail_i       (tail_q),
    .cnt_i        (cnt_q),
    .head_o       (head_d),
    .tail_o       (tail_d),
    .flags_o      (fl),
    .l_wr1_addr_o (l_wr1_addr),
    .l_wr1_data_o (l_wr1_data),
    .l_wr2_addr_o (l_wr2_addr),
    .l_wr2_data_o (l_wr2_data),
    .r_wr1_addr_o (r_wr1_addr),
    .r_wr1_data_o (r_wr1_data),
    .r_wr2_addr_o (r_wr2_addr),
    .r_wr2_data_o (r_wr2_data),
    .res_o        (res_beat)
  );

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ctl.accept) begin
      req_q        <= in_data_i;
      fwd_l_data_q <= l_wr2_data_q;
      fwd_r_data_q <= r_wr2_data_q;
    end
    if (ctl.exec) begin
      l_wr2_addr_q <= l_wr2_addr;
      l_wr2_data_q <= l_wr2_data;
      r_wr2_addr_q <= r_wr2_addr;
      r_wr2_data_q <= r_wr2_data;
      res_q        <= res_beat;
    end
    if (res_move) begin
      out_q <= res_q;
    end
  end

  // Control and list registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= LinkW'(1);
      l0_ok_q     <= 1'b0;
      r0_ok_q     <= 1'b0;
      l0_none_q   <= 1'b0;
      r0_none_q   <= 1'b0;
      fwd_l_q     <= 1'b0;
      fwd_r_q     <= 1'b0;
      l_wr2_en_q  <= 1'b0;
      r_wr2_en_q  <= 1'b0;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (l_we && (l_waddr == '0)) begin
        l0_ok_q <= 1'b1;
      end
      if (r_we && (r_waddr == '0)) begin
        r0_ok_q <= 1'b1;
      end
      if (ctl.accept) begin
        l0_none_q <= (rd_addr == '0) && !l0_ok_q;
        r0_none_q <= (rd_addr == '0) && !r0_ok_q;
        fwd_l_q   <= ctl.wr2 && l_wr2_en_q && (l_wr2_addr_q == rd_addr);
        fwd_r_q   <= ctl.wr2 && r_wr2_en_q && (r_wr2_addr_q == rd_addr);
      end
      if (ctl.exec) begin
        head_q     <= head_d;
        tail_q     <= tail_d;
        l_wr2_en_q <= fl.l_wr2;
        r_wr2_en_q <= fl.r_wr2;
        if (fl.grow) begin
          cnt_q <= cnt_q + LinkW'(1);
        end
      end
      if (ctl.exec) begin
        res_valid_q <= 1'b1;
      end else if (res_move) begin
        res_valid_q <= 1'b0;
      end
      if (res_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A second write cycle only ever follows an execute cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.wr2 |-> $past(ctl.exec))
    else $error("second write cycle without a preceding execute cycle");

  // Every execute cycle belongs to a beat accepted in the cycle before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.exec |-> $past(ctl.accept))
    else $error("execute cycle without an accepted beat");

  // The id counter stays between one and the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q <= LinkW'(MaxNodes)))
    else $error("node counter out of range");

  // Forwarding is only set up from a read that overlapped a second write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.exec && (fwd_l_q || fwd_r_q)) |-> $past(ctl.wr2))
    else $error("forwarded link data without an overlapping write");

endmodule
